// ===== rtl/core/sorted_priority_queue_macros.svh =====
// Shared assertion macros
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication
`define SPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_priority_queue: assertion failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_priority_queue: assertion failed");

// delayed implication
`define SPQ_ASSERT_DELAY2(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("sorted_priority_queue: assertion failed");

`endif

// ===== rtl/core/spq_pkg.sv =====
package spq_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic               command;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    status_e            status;
  } out_t;

  typedef struct packed {
    logic    load;
    logic    do_insert;
    logic    do_pop;
    logic    store_result;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    logic is_pop;
    logic empty;
    logic full;
  } dp_stat_t;

endpackage

// ===== rtl/core/spq_ctrl.sv =====
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::dp_stat_t stat,
  output spq_pkg::dp_cmd_t  cmd
);
  import spq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    cmd.load         = 1'b0;
    cmd.do_insert    = 1'b0;
    cmd.do_pop       = 1'b0;
    cmd.store_result = 1'b0;
    cmd.status       = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = start;
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.store_result = 1'b1;
        if (stat.is_pop) begin
          if (stat.empty) begin
            cmd.status = ST_EMPTY;
          end else begin
            cmd.do_pop = 1'b1;
          end
        end else begin
          if (stat.full) begin
            cmd.status = ST_FULL;
          end else begin
            cmd.do_insert = 1'b1;
          end
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== rtl/core/spq_datapath.sv =====
module spq_datapath #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  spq_pkg::in_t      in_item,
  input  spq_pkg::dp_cmd_t  cmd,
  output spq_pkg::dp_stat_t stat,
  output logic              out_valid,
  output spq_pkg::out_t     out_result
);
  import spq_pkg::*;

  localparam int OCC_W = $clog2(DEPTH + 1);

  logic signed [31:0] ent_r [DEPTH];
  logic signed [31:0] ins_src [DEPTH];
  logic signed [31:0] pop_src [DEPTH];
  logic [DEPTH-1:0]   gt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  in_t                item_r;
  out_t               result_r;
  logic               out_valid_r;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    assign gt[k] = (occ_r <= OCC_W'(k)) || ($signed(ent_r[k]) > $signed(item_r.value));

    if (k == 0) begin : g_head
      assign ins_src[k] = item_r.value;
    end else begin : g_body
      assign ins_src[k] = gt[k-1] ? ent_r[k-1] : item_r.value;
    end

    if (k == DEPTH - 1) begin : g_tail
      assign pop_src[k] = ent_r[k];
    end else begin : g_link
      assign pop_src[k] = ent_r[k+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.do_insert && gt[k]) begin
        ent_r[k] <= ins_src[k];
      end else if (cmd.do_pop) begin
        ent_r[k] <= pop_src[k];
      end
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    priority if (cmd.do_insert) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (cmd.do_pop) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= cmd.store_result;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.store_result) begin
      result_r.popped_value <= cmd.do_pop ? ent_r[0] : '0;
      result_r.status       <= cmd.status;
    end
  end

  assign stat.is_pop = (item_r.command == CMD_POP);
  assign stat.empty  = (occ_r == '0);
  assign stat.full   = (occ_r == OCC_W'(DEPTH));

  assign out_valid  = out_valid_r;
  assign out_result = result_r;

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// An accepted start moves the controller into its execute state; the store
// strobe issued there is registered into out_valid. Starts are taken only while
// idle. Every cell of the sorted register chain compares and shifts at once.
// Reset: synchronous, active low; clears occupancy, controller and strobe.
// Stored values are undefined until written. The receiver cannot stall:
// each result is shown for exactly one cycle.
module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::in_t  in_item,
  output logic          out_valid,
  output spq_pkg::out_t out_result
);
  import spq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

// ===== rtl/core/spq_checker.sv =====
`include "sorted_priority_queue_macros.svh"

module spq_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input spq_pkg::out_t out_result
);
  import spq_pkg::*;

  logic err_beat;

  assign err_beat = out_valid && (out_result.status != ST_OK);

  `SPQ_ASSERT_DELAY2(a_beat_gets_result, clk, rst_n, start && !busy, out_valid)
  `SPQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, start && !busy, busy)
  `SPQ_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
  `SPQ_ASSERT_IMPLY(a_error_zero_value, clk, rst_n, err_beat, out_result.popped_value == '0)

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_result (out_result)
);
